// ----- rtl/core/hub75_pkg.sv -----
// Shared types, constants and helpers for the HUB75 scan driver.
`timescale 1ns / 1ps

package hub75_pkg;

  localparam int WIDTH_PIXELS   = 64;
  localparam int ROW_PAIR_COUNT = 32;
  localparam int PLANE_COUNT    = 5;

  localparam int STORE_ROW_W = 6;
  localparam int STORE_COL_W = 6;
  localparam int ADDR_W      = STORE_ROW_W + STORE_COL_W;
  localparam int PIX_W       = 15;

  localparam int ROW_W    = 5;
  localparam int PLANE_W  = 3;
  localparam int ON_W     = 20;
  localparam int BASE_W   = 16;
  localparam int WEIGHT_W = 4;
  localparam int COLOR_W  = 5;
  localparam int BITS_W   = 6;

  localparam logic [BASE_W-1:0] BASE_TIME_RESET = 16'd64;

  // Function codes carried in tuser
  localparam logic [1:0] FUNC_PIXEL   = 2'd0;
  localparam logic [1:0] FUNC_REFRESH = 2'd1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN
  } ctrl_state_e;

  typedef struct packed {
    logic [1:0]             func;
    logic [STORE_ROW_W-1:0] pix_row;
    logic [STORE_COL_W-1:0] pix_col;
    logic [COLOR_W-1:0]     red;
    logic [COLOR_W-1:0]     green;
    logic [COLOR_W-1:0]     blue;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0]   latch_row;
    logic [PLANE_W-1:0] latch_plane;
    logic [ON_W-1:0]    on_time;
    logic [BITS_W-1:0]  color_bits;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [PIX_W-1:0]  wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr_top;
    logic [ADDR_W-1:0] raddr_bot;
  } ram_req_t;

  function automatic logic [WEIGHT_W-1:0] plane_weight(input logic [PLANE_W-1:0] plane);
    logic [WEIGHT_W-1:0] w;
    unique case (plane)
      3'd0:    w = 4'd1;
      3'd1:    w = 4'd2;
      3'd2:    w = 4'd4;
      3'd3:    w = 4'd8;
      3'd4:    w = 4'd12;
      default: w = 4'd0;
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/core/hub75_bcm_scan_driver.sv -----
// Top level of the HUB75 binary code modulation scan driver.
`timescale 1ns / 1ps

// After reset the block sweeps the 4096-entry frame store to zero, one entry per
// cycle, and accepts no item until the sweep is done; base_time writes are taken
// at any time. A pixel write (tuser 0) is written to the frame store as it is
// taken. A refresh step (tuser 1) latches the current row pair and plane and then
// streams 64 column items, one per cycle while the sink is ready, paced by the
// column counter that reads the top and bottom pixel through the frame RAM's two
// read ports; each column read passes the RAM output register and then the output
// register before it is offered, and the next item is taken in the cycle after
// the last column item has gone. Error items (tuser 2 and 3) are accepted and
// dropped.
module hub75_bcm_scan_driver (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,     // base_time
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // pix_row, pix_col, red, green, blue, zero pad
  input  logic [1:0]  s_axis_tuser,   // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // latch_row, latch_plane, on_time, color_bits, pad
  output logic        m_axis_tlast
);

  logic [hub75_pkg::BASE_W-1:0]  base_time_q;
  hub75_pkg::in_item_t           in_item;
  hub75_pkg::out_item_t          out_item;
  hub75_pkg::ram_req_t           ram_req;
  logic [hub75_pkg::PIX_W-1:0]   rdata_top, rdata_bot;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_time_q <= hub75_pkg::BASE_TIME_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      base_time_q <= cfg_data_i;
    end
  end

  assign in_item.func    = s_axis_tuser;
  assign in_item.pix_row = s_axis_tdata[5:0];
  assign in_item.pix_col = s_axis_tdata[11:6];
  assign in_item.red     = s_axis_tdata[16:12];
  assign in_item.green   = s_axis_tdata[21:17];
  assign in_item.blue    = s_axis_tdata[26:22];

  hub75_scan_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .base_time_i (base_time_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_item_i   (in_item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_item_o  (out_item),
    .ram_req_o   (ram_req),
    .rdata_top_i (rdata_top),
    .rdata_bot_i (rdata_bot)
  );

  hub75_frame_ram u_ram (
    .clk_i       (clk_i),
    .req_i       (ram_req),
    .rdata_top_o (rdata_top),
    .rdata_bot_o (rdata_bot)
  );

  assign m_axis_tdata = {6'b0, out_item.color_bits, out_item.on_time,
                         out_item.latch_plane, out_item.latch_row};
  assign m_axis_tlast = out_item.last;

endmodule

// ----- rtl/core/hub75_frame_ram.sv -----
// Frame store: one write port and two registered read ports.
`timescale 1ns / 1ps

module hub75_frame_ram (
  input  logic                         clk_i,
  input  hub75_pkg::ram_req_t          req_i,
  output logic [hub75_pkg::PIX_W-1:0]  rdata_top_o,
  output logic [hub75_pkg::PIX_W-1:0]  rdata_bot_o
);

  logic [hub75_pkg::PIX_W-1:0] mem [2**hub75_pkg::ADDR_W];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // read data holds while no read is issued, so the stage can stall
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_top_o <= mem[req_i.raddr_top];
      rdata_bot_o <= mem[req_i.raddr_bot];
    end
  end

endmodule

// ----- rtl/core/hub75_scan_ctrl.sv -----
// Scan controller: clearing sweep, pixel writes, row/plane sequencing and readout.
`timescale 1ns / 1ps

module hub75_scan_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [hub75_pkg::BASE_W-1:0]      base_time_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  hub75_pkg::in_item_t               in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output hub75_pkg::out_item_t              out_item_o,
  output hub75_pkg::ram_req_t               ram_req_o,
  input  logic [hub75_pkg::PIX_W-1:0]       rdata_top_i,
  input  logic [hub75_pkg::PIX_W-1:0]       rdata_bot_i
);

  localparam logic [hub75_pkg::STORE_COL_W-1:0] LastCol =
    hub75_pkg::STORE_COL_W'(hub75_pkg::WIDTH_PIXELS - 1);
  localparam logic [hub75_pkg::ROW_W-1:0] LastRow =
    hub75_pkg::ROW_W'(hub75_pkg::ROW_PAIR_COUNT - 1);
  localparam logic [hub75_pkg::PLANE_W-1:0] LastPlane =
    hub75_pkg::PLANE_W'(hub75_pkg::PLANE_COUNT - 1);
  localparam logic [hub75_pkg::ADDR_W-1:0] LastAddr = '1;

  hub75_pkg::ctrl_state_e state_q, state_d;

  logic [hub75_pkg::ADDR_W-1:0]      clr_q;
  logic [hub75_pkg::ROW_W-1:0]       row_q;
  logic [hub75_pkg::PLANE_W-1:0]     plane_q;
  logic [hub75_pkg::ROW_W-1:0]       lrow_q;
  logic [hub75_pkg::PLANE_W-1:0]     lplane_q;
  logic [hub75_pkg::ON_W-1:0]        on_q;
  logic [hub75_pkg::ROW_W-1:0]       erow_q;
  logic [hub75_pkg::PLANE_W-1:0]     eplane_q;
  logic [hub75_pkg::STORE_COL_W-1:0] col_q;
  logic                              issue_done_q;
  logic                              s1_vld_q, s1_last_q;
  logic                              s2_vld_q, s2_last_q;
  logic [hub75_pkg::BITS_W-1:0]      s2_bits_q;

  logic                              accept, start;
  logic                              s2_load, s1_move, issue;
  logic [hub75_pkg::ROW_W-1:0]       nrow;
  logic [hub75_pkg::PLANE_W-1:0]     nplane;
  logic [hub75_pkg::ON_W-1:0]        on_time;
  logic [hub75_pkg::STORE_ROW_W-1:0] top_row, bot_row;

  function automatic logic [hub75_pkg::BITS_W-1:0] color_byte(
    input logic [hub75_pkg::PIX_W-1:0]   top,
    input logic [hub75_pkg::PIX_W-1:0]   bot,
    input logic [hub75_pkg::PLANE_W-1:0] sh
  );
    logic [hub75_pkg::COLOR_W-1:0] tr, tg, tb, br, bg, bb;
    tr = top[4:0];
    tg = top[9:5];
    tb = top[14:10];
    br = bot[4:0];
    bg = bot[9:5];
    bb = bot[14:10];
    return {bb[sh], bg[sh], br[sh], tb[sh], tg[sh], tr[sh]};
  endfunction

  assign in_ready_o = (state_q == hub75_pkg::ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign start      = accept && (in_item_i.func == hub75_pkg::FUNC_REFRESH);

  // next row pair and plane after the one being latched
  always_comb begin
    if (row_q == LastRow) begin
      nrow   = '0;
      nplane = (plane_q == LastPlane) ? '0 : plane_q + 1'b1;
    end else begin
      nrow   = row_q + 1'b1;
      nplane = plane_q;
    end
  end

  assign on_time = hub75_pkg::ON_W'(hub75_pkg::plane_weight(plane_q)) *
                   hub75_pkg::ON_W'(base_time_i);

  // two-stage readout: RAM output register, then output register
  assign s2_load = !s2_vld_q || out_ready_i;
  assign s1_move = s1_vld_q && s2_load;
  assign issue   = (state_q == hub75_pkg::ST_SCAN) && !issue_done_q &&
                   (!s1_vld_q || s1_move);

  assign top_row = hub75_pkg::STORE_ROW_W'(erow_q);
  assign bot_row = hub75_pkg::STORE_ROW_W'(erow_q) +
                   hub75_pkg::STORE_ROW_W'(hub75_pkg::ROW_PAIR_COUNT);

  always_comb begin
    ram_req_o           = '0;
    ram_req_o.re        = issue;
    ram_req_o.raddr_top = {top_row, col_q};
    ram_req_o.raddr_bot = {bot_row, col_q};
    if (state_q == hub75_pkg::ST_CLEAR) begin
      ram_req_o.we    = 1'b1;
      ram_req_o.waddr = clr_q;
      ram_req_o.wdata = '0;
    end else begin
      ram_req_o.we    = accept && (in_item_i.func == hub75_pkg::FUNC_PIXEL);
      ram_req_o.waddr = {in_item_i.pix_row, in_item_i.pix_col};
      ram_req_o.wdata = {in_item_i.blue, in_item_i.green, in_item_i.red};
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hub75_pkg::ST_CLEAR: begin
        if (clr_q == LastAddr) state_d = hub75_pkg::ST_IDLE;
      end
      hub75_pkg::ST_IDLE: begin
        if (start) state_d = hub75_pkg::ST_SCAN;
      end
      hub75_pkg::ST_SCAN: begin
        if (s2_vld_q && s2_last_q && out_ready_i) state_d = hub75_pkg::ST_IDLE;
      end
      default: state_d = hub75_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hub75_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q        <= '0;
      row_q        <= '0;
      plane_q      <= '0;
      col_q        <= '0;
      issue_done_q <= 1'b1;
      s1_vld_q     <= 1'b0;
      s2_vld_q     <= 1'b0;
    end else begin
      if (state_q == hub75_pkg::ST_CLEAR) clr_q <= clr_q + 1'b1;
      if (start) begin
        row_q        <= nrow;
        plane_q      <= nplane;
        col_q        <= '0;
        issue_done_q <= 1'b0;
      end else if (issue) begin
        col_q <= col_q + 1'b1;
        if (col_q == LastCol) issue_done_q <= 1'b1;
      end
      if (issue) begin
        s1_vld_q <= 1'b1;
      end else if (s1_move) begin
        s1_vld_q <= 1'b0;
      end
      if (s2_load) s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      lrow_q   <= row_q;
      lplane_q <= plane_q;
      on_q     <= on_time;
      erow_q   <= nrow;
      eplane_q <= nplane;
    end
    if (issue) s1_last_q <= (col_q == LastCol);
    if (s1_move) begin
      s2_bits_q <= color_byte(rdata_top_i, rdata_bot_i, eplane_q);
      s2_last_q <= s1_last_q;
    end
  end

  assign out_valid_o            = s2_vld_q;
  assign out_item_o.latch_row   = lrow_q;
  assign out_item_o.latch_plane = lplane_q;
  assign out_item_o.on_time     = on_q;
  assign out_item_o.color_bits  = s2_bits_q;
  assign out_item_o.last        = s2_last_q;

endmodule

// ----- rtl/core/hub75_scan_chk.sv -----
// Port-level checks for the HUB75 scan driver, bound to the top level.
`timescale 1ns / 1ps

module hub75_scan_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // a stalled output item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output item changed while stalled");

  // no input is taken while a row transfer is still being delivered
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input ready during row transfer");

  a_refresh_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == hub75_pkg::FUNC_REFRESH
    |=> !s_axis_tready)
    else $error("input ready right after refresh step");

  // the last column item closes the transfer
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
    else $error("output item after end of row");

endmodule

bind hub75_bcm_scan_driver hub75_scan_chk u_chk (.*);
